### rtl/core/ctnk_pkg.sv
// Shared constants, codes and types of the cosine top-k neighbour search block.
`default_nettype none
package ctnk_pkg;

    localparam int DEF_MAX_TOKENS = 1024;
    localparam int DEF_MAX_DIM    = 256;
    localparam int DEF_MAX_K      = 64;

    localparam int TOK_W      = 10;
    localparam int COMP_W     = 8;
    localparam int VAL_W      = 16;
    localparam int SIM_W      = 16;
    localparam int LIM_W      = 7;
    localparam int TCNT_W     = 11;
    localparam int VLEN_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;
    localparam int QUOT_W     = 17;
    localparam int FRAC_SHIFT = 19;

    localparam logic signed [SIM_W-1:0] THR_RESET  = 16'sd3277;
    localparam logic [LIM_W-1:0]        LIM_RESET  = 7'd64;
    localparam logic [TCNT_W-1:0]       TCNT_RESET = 11'd1024;
    localparam logic [VLEN_W-1:0]       VLEN_RESET = 9'd256;

    localparam logic signed [SIM_W-1:0] SIM_MAX = 16'sh7FFF;
    localparam logic signed [SIM_W-1:0] SIM_MIN = 16'sh8000;
    localparam logic [QUOT_W-1:0]       QUOT_POS_LIM = 17'd32767;
    localparam logic [QUOT_W-1:0]       QUOT_NEG_LIM = 17'd32768;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_LIMIT     = 2'd1,
        CFG_TOKENS    = 2'd2,
        CFG_VLEN      = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic clear;
        logic insert;
        logic pop;
    } list_ctrl_t;

    typedef struct packed {
        logic head_valid;
        logic more;
    } list_stat_t;

endpackage
`default_nettype wire

### rtl/core/ctnk_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ctnk_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

### rtl/core/ctnk_mac.sv
// Shared multiply-accumulate unit: dot product and squared norm (sum of squares) of the second operand.
`default_nettype none
module ctnk_mac #(
    parameter int DOT_W  = 41,
    parameter int NORM_W = 40
) (
    input  logic                     clk,
    input  logic                     clear,
    input  logic                     enable,
    input  logic signed [15:0]       a,
    input  logic signed [15:0]       b,
    output logic signed [DOT_W-1:0]  dot,
    output logic [NORM_W-1:0]        norm
);

    logic signed [DOT_W-1:0] dot_reg, dot_next;
    logic [NORM_W-1:0]       norm_reg, norm_next;
    logic signed [31:0]      prod_ab;
    logic signed [31:0]      prod_bb;

    always_comb
    begin
        prod_ab   = a * b;
        prod_bb   = b * b;
        dot_next  = dot_reg;
        norm_next = norm_reg;
        if (clear)
        begin
            dot_next  = '0;
            norm_next = '0;
        end
        else if (enable)
        begin
            dot_next  = dot_reg + DOT_W'(prod_ab);
            norm_next = norm_reg + NORM_W'(unsigned'(prod_bb));
        end
    end

    always_ff @(posedge clk)
    begin
        dot_reg  <= dot_next;
        norm_reg <= norm_next;
    end

    assign dot  = dot_reg;
    assign norm = norm_reg;

endmodule
`default_nettype wire

### rtl/core/ctnk_isqrt.sv
// Iterative floor square root, one result bit per cycle.
`default_nettype none
module ctnk_isqrt #(
    parameter int RW = 22
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [2*RW-1:0] radicand,
    output logic            done,
    output logic [RW-1:0]   root
);

    localparam int SW = $clog2(RW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [SW-1:0]   step_reg, step_next;
    logic [2*RW-1:0] rad_reg, rad_next;
    logic [RW+1:0]   rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [RW+1:0]   rem_sh;
    logic [RW+1:0]   trial;

    always_comb
    begin
        rem_sh    = {rem_reg[RW-1:0], rad_reg[2*RW-1:2*RW-2]};
        trial     = {root_reg, 2'b01};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = SW'(RW);
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[2*RW-3:0], 2'b00};
            step_next = step_reg - 1'b1;
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[RW-2:0], 1'b0};
            end
            if (step_reg == SW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

### rtl/core/ctnk_div.sv
// Restoring divider, one quotient bit per cycle, with sticky overflow.
`default_nettype none
module ctnk_div #(
    parameter int NW = 60,
    parameter int DW = 44
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [NW-1:0]                 num,
    input  logic [DW-1:0]                 den,
    output logic                          done,
    output logic [ctnk_pkg::QUOT_W-1:0]   quot,
    output logic                          ovf
);

    localparam int QW = ctnk_pkg::QUOT_W;
    localparam int SW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [SW-1:0] step_reg, step_next;
    logic [NW-1:0] num_reg, num_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [QW-1:0] q_reg, q_next;
    logic          ovf_reg, ovf_next;
    logic [DW:0]   rem_sh;
    logic          ge;

    always_comb
    begin
        rem_sh    = {rem_reg, num_reg[NW-1]};
        ge        = rem_sh >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = SW'(NW);
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            q_next    = '0;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            num_next  = {num_reg[NW-2:0], 1'b0};
            step_next = step_reg - 1'b1;
            rem_next  = ge ? DW'(rem_sh - {1'b0, den_reg}) : DW'(rem_sh);
            q_next    = {q_reg[QW-2:0], ge};
            ovf_next  = ovf_reg | q_reg[QW-1];
            if (step_reg == SW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        ovf_reg  <= ovf_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign ovf  = ovf_reg;

endmodule
`default_nettype wire

### rtl/core/ctnk_list.sv
// Sorted best-neighbour list as a row of insertion cells, popped from the head.
`default_nettype none
module ctnk_list #(
    parameter int K  = 64,
    parameter int IW = 10,
    parameter int KW = 7
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ctnk_pkg::list_ctrl_t              ctrl,
    input  logic signed [ctnk_pkg::SIM_W-1:0] ins_sim,
    input  logic [IW-1:0]                     ins_idx,
    input  logic [KW-1:0]                     limit,
    output ctnk_pkg::list_stat_t              stat,
    output logic signed [ctnk_pkg::SIM_W-1:0] head_sim,
    output logic [IW-1:0]                     head_idx
);

    localparam int SW = ctnk_pkg::SIM_W;

    logic signed [SW-1:0] sim_reg [K];
    logic signed [SW-1:0] sim_next [K];
    logic [IW-1:0]        idx_reg [K];
    logic [IW-1:0]        idx_next [K];
    logic [K-1:0]         valid_reg, valid_next;
    logic [K-1:0]         ins;
    logic [K:0]           valid_pad;

    always_comb
    begin
        valid_pad = {1'b0, valid_reg};
        for (int i = 0; i < K; i++)
        begin
            ins[i] = !valid_reg[i] || (ins_sim > sim_reg[i])
                     || ((ins_sim == sim_reg[i]) && (ins_idx > idx_reg[i]));
        end
        for (int i = 0; i < K; i++)
        begin
            sim_next[i]   = sim_reg[i];
            idx_next[i]   = idx_reg[i];
            valid_next[i] = valid_reg[i];
            priority if (ctrl.clear)
            begin
                valid_next[i] = 1'b0;
            end
            else if (ctrl.insert)
            begin
                if (i < int'(limit))
                begin
                    if ((i > 0) && ins[(i > 0) ? i - 1 : 0])
                    begin
                        sim_next[i]   = sim_reg[(i > 0) ? i - 1 : 0];
                        idx_next[i]   = idx_reg[(i > 0) ? i - 1 : 0];
                        valid_next[i] = valid_reg[(i > 0) ? i - 1 : 0];
                    end
                    else if (ins[i])
                    begin
                        sim_next[i]   = ins_sim;
                        idx_next[i]   = ins_idx;
                        valid_next[i] = 1'b1;
                    end
                end
            end
            else if (ctrl.pop)
            begin
                valid_next[i] = valid_pad[i+1];
                if (i + 1 < K)
                begin
                    sim_next[i] = sim_reg[(i + 1 < K) ? i + 1 : i];
                    idx_next[i] = idx_reg[(i + 1 < K) ? i + 1 : i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < K; i++)
        begin
            sim_reg[i] <= sim_next[i];
            idx_reg[i] <= idx_next[i];
        end
    end

    assign stat.head_valid = valid_reg[0];
    assign stat.more       = valid_pad[1];
    assign head_sim        = sim_reg[0];
    assign head_idx        = idx_reg[0];

endmodule
`default_nettype wire

### rtl/core/cosine_top_k_neighbors_top.sv
// Top level of the cosine-similarity top-k neighbour search block.
// A load request writes one Q3.12 component into the embedding store.
// A query request reads the source vector once and takes its 22-step square root (at default
// sizes), then for every other token below token_count runs the vector through the shared
// multiply-accumulate unit, a 22-step square root, one multiply, and a 60-step divide when
// both norms are non-zero; results then leave at one per cycle when the output is not
// stalled. Each token's work is serialised by the single store read port feeding the
// multiply-accumulate unit and by the bit-serial root and divide units.
`default_nettype none
module cosine_top_k_neighbors_top #(
    parameter int MAX_TOKENS = ctnk_pkg::DEF_MAX_TOKENS,
    parameter int MAX_DIM    = ctnk_pkg::DEF_MAX_DIM,
    parameter int MAX_K      = ctnk_pkg::DEF_MAX_K
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // token_index[9:0], component_index[17:10], component_value[33:18], zero pad
    input  logic [ctnk_pkg::S_TDATA_W-1:0]      s_tdata,
    // req_type[0]
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // source_index[9:0], target_index[19:10], similarity[35:20], zero pad
    output logic [ctnk_pkg::M_TDATA_W-1:0]      m_tdata,
    // has_match[0]
    output logic [0:0]                          m_tuser,
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ctnk_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ctnk_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int TOK_W   = ctnk_pkg::TOK_W;
    localparam int SIM_W   = ctnk_pkg::SIM_W;
    localparam int TokAw   = $clog2(MAX_TOKENS);
    localparam int DimAw   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int StoreDepth = MAX_TOKENS * (2 ** DimAw);
    localparam int JW      = $clog2(MAX_TOKENS + 1);
    localparam int CW      = $clog2(MAX_DIM + 1);
    localparam int KW      = $clog2(MAX_K + 1);
    localparam int NormW   = 31 + DimAw;
    localparam int DotW    = NormW + 1;
    localparam int RootW   = (NormW + 5) / 2;
    localparam int DenW    = 2 * RootW;
    localparam int NumW    = ((NormW + 20 > DenW) ? NormW + 20 : DenW) + 1;

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_SRC_MAC  = 11'b000_0000_0010,
        ST_SRC_ROOT = 11'b000_0000_0100,
        ST_SELECT   = 11'b000_0000_1000,
        ST_TGT_MAC  = 11'b000_0001_0000,
        ST_TGT_ROOT = 11'b000_0010_0000,
        ST_DEN      = 11'b000_0100_0000,
        ST_CHECK    = 11'b000_1000_0000,
        ST_DIV      = 11'b001_0000_0000,
        ST_OFFER    = 11'b010_0000_0000,
        ST_DRAIN    = 11'b100_0000_0000
    } state_t;

    logic                          in_req;
    logic [TOK_W-1:0]              in_tok;
    logic [ctnk_pkg::COMP_W-1:0]   in_comp;
    logic [ctnk_pkg::VAL_W-1:0]    in_val;
    logic                          in_acc;

    logic signed [SIM_W-1:0]       thr_reg, thr_next;
    logic [ctnk_pkg::LIM_W-1:0]    lim_reg, lim_next;
    logic [ctnk_pkg::TCNT_W-1:0]   tcnt_reg, tcnt_next;
    logic [ctnk_pkg::VLEN_W-1:0]   vlen_reg, vlen_next;
    logic [JW-1:0]                 tcount_eff;
    logic [CW-1:0]                 vlen_eff;
    logic [KW-1:0]                 limit_eff;

    state_t                        state_reg, state_next;
    logic [TOK_W-1:0]              src_reg, src_next;
    logic [JW-1:0]                 j_reg, j_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic                          rdv_reg, rdv_next;
    logic [DimAw-1:0]              wc_reg, wc_next;
    logic [RootW-1:0]              ra_reg, ra_next;
    logic [DenW-1:0]               den_reg, den_next;
    logic signed [SIM_W-1:0]       sim_reg, sim_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [TOK_W-1:0]              out_src_reg, out_src_next;
    logic [TOK_W-1:0]              out_tgt_reg, out_tgt_next;
    logic signed [SIM_W-1:0]       out_sim_reg, out_sim_next;
    logic                          out_match_reg, out_match_next;
    logic                          out_last_reg, out_last_next;

    logic                          load_ok;
    logic                          issue;
    logic                          mac_done;
    logic                          mac_clear;
    logic [TokAw-1:0]              rd_tok;
    logic [ctnk_pkg::VAL_W-1:0]    store_rdata;
    logic [ctnk_pkg::VAL_W-1:0]    sbuf_rdata;
    logic signed [15:0]            mac_a;
    logic signed [DotW-1:0]        mac_dot;
    logic [NormW-1:0]              mac_norm;
    logic                          sq_start;
    logic                          sq_done;
    logic [RootW-1:0]              sq_root;
    logic                          div_start;
    logic                          div_done;
    logic [ctnk_pkg::QUOT_W-1:0]   div_q;
    logic                          div_ovf;
    logic [DotW-1:0]               mag;
    logic [NumW-1:0]               div_num;
    logic signed [ctnk_pkg::QUOT_W:0] q_s;
    logic signed [SIM_W-1:0]       sim_sat;
    logic                          out_load;
    ctnk_pkg::list_ctrl_t          lctl;
    ctnk_pkg::list_stat_t          lstat;
    logic signed [SIM_W-1:0]       head_sim;
    logic [TokAw-1:0]              head_idx;

    assign in_req  = s_tuser[0];
    assign in_tok  = s_tdata[9:0];
    assign in_comp = s_tdata[17:10];
    assign in_val  = s_tdata[33:18];
    assign in_acc  = s_tvalid && s_tready;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        thr_next  = thr_reg;
        lim_next  = lim_reg;
        tcnt_next = tcnt_reg;
        vlen_next = vlen_reg;
        if (cfg_valid)
        begin
            unique case (ctnk_pkg::cfg_reg_t'(cfg_index))
                ctnk_pkg::CFG_THRESHOLD: thr_next  = cfg_data;
                ctnk_pkg::CFG_LIMIT:     lim_next  = cfg_data[ctnk_pkg::LIM_W-1:0];
                ctnk_pkg::CFG_TOKENS:    tcnt_next = cfg_data[ctnk_pkg::TCNT_W-1:0];
                ctnk_pkg::CFG_VLEN:      vlen_next = cfg_data[ctnk_pkg::VLEN_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= ctnk_pkg::THR_RESET;
            lim_reg  <= ctnk_pkg::LIM_RESET;
            tcnt_reg <= ctnk_pkg::TCNT_RESET;
            vlen_reg <= ctnk_pkg::VLEN_RESET;
        end
        else
        begin
            thr_reg  <= thr_next;
            lim_reg  <= lim_next;
            tcnt_reg <= tcnt_next;
            vlen_reg <= vlen_next;
        end
    end

    assign tcount_eff = (int'(tcnt_reg) < MAX_TOKENS) ? JW'(tcnt_reg) : JW'(MAX_TOKENS);
    assign vlen_eff   = (int'(vlen_reg) < MAX_DIM) ? CW'(vlen_reg) : CW'(MAX_DIM);
    assign limit_eff  = (int'(lim_reg) < MAX_K) ? KW'(lim_reg) : KW'(MAX_K);

    assign load_ok = in_acc && (in_req == ctnk_pkg::REQ_LOAD)
                     && (int'(in_tok) < MAX_TOKENS) && (int'(in_comp) < MAX_DIM);

    assign issue    = ((state_reg == ST_SRC_MAC) || (state_reg == ST_TGT_MAC))
                      && (cnt_reg < vlen_eff);
    assign mac_done = (cnt_reg == vlen_eff) && !rdv_reg;
    assign rd_tok   = (state_reg == ST_SRC_MAC) ? TokAw'(src_reg) : TokAw'(j_reg);
    assign mac_a    = (state_reg == ST_SRC_MAC) ? signed'(store_rdata) : signed'(sbuf_rdata);

    ctnk_ram #(
        .WIDTH (ctnk_pkg::VAL_W),
        .DEPTH (StoreDepth)
    ) u_store (
        .clk   (clk),
        .we    (load_ok),
        .waddr ({TokAw'(in_tok), DimAw'(in_comp)}),
        .wdata (in_val),
        .re    (issue),
        .raddr ({rd_tok, DimAw'(cnt_reg)}),
        .rdata (store_rdata)
    );

    ctnk_ram #(
        .WIDTH (ctnk_pkg::VAL_W),
        .DEPTH (MAX_DIM)
    ) u_srcbuf (
        .clk   (clk),
        .we    ((state_reg == ST_SRC_MAC) && rdv_reg),
        .waddr (wc_reg),
        .wdata (store_rdata),
        .re    (issue && (state_reg == ST_TGT_MAC)),
        .raddr (DimAw'(cnt_reg)),
        .rdata (sbuf_rdata)
    );

    ctnk_mac #(
        .DOT_W  (DotW),
        .NORM_W (NormW)
    ) u_mac (
        .clk    (clk),
        .clear  (mac_clear),
        .enable (rdv_reg),
        .a      (mac_a),
        .b      (signed'(store_rdata)),
        .dot    (mac_dot),
        .norm   (mac_norm)
    );

    ctnk_isqrt #(
        .RW (RootW)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand ((2 * RootW)'({mac_norm, 4'b0000})),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign mag     = mac_dot[DotW-1] ? DotW'(-mac_dot) : DotW'(mac_dot);
    assign div_num = (NumW'(mag) << ctnk_pkg::FRAC_SHIFT) + NumW'(den_reg >> 1);

    ctnk_div #(
        .NW (NumW),
        .DW (DenW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_q),
        .ovf   (div_ovf)
    );

    ctnk_list #(
        .K  (MAX_K),
        .IW (TokAw),
        .KW (KW)
    ) u_list (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (lctl),
        .ins_sim  (sim_reg),
        .ins_idx  (TokAw'(j_reg)),
        .limit    (limit_eff),
        .stat     (lstat),
        .head_sim (head_sim),
        .head_idx (head_idx)
    );

    always_comb
    begin
        q_s = signed'({1'b0, div_q});
        if (mac_dot[DotW-1])
        begin
            sim_sat = (div_ovf || (div_q >= ctnk_pkg::QUOT_NEG_LIM)) ? ctnk_pkg::SIM_MIN
                                                                     : SIM_W'(-q_s);
        end
        else
        begin
            sim_sat = (div_ovf || (div_q >= ctnk_pkg::QUOT_POS_LIM)) ? ctnk_pkg::SIM_MAX
                                                                     : SIM_W'(q_s);
        end
    end

    assign out_load = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        src_next       = src_reg;
        j_next         = j_reg;
        cnt_next       = cnt_reg;
        rdv_next       = issue;
        wc_next        = wc_reg;
        ra_next        = ra_reg;
        den_next       = den_reg;
        sim_next       = sim_reg;
        mac_clear      = 1'b0;
        sq_start       = 1'b0;
        div_start      = 1'b0;
        lctl           = '0;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        out_src_next   = out_src_reg;
        out_tgt_next   = out_tgt_reg;
        out_sim_next   = out_sim_reg;
        out_match_next = out_match_reg;
        out_last_next  = out_last_reg;

        if (issue)
        begin
            cnt_next = cnt_reg + 1'b1;
            wc_next  = DimAw'(cnt_reg);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (in_req == ctnk_pkg::REQ_QUERY))
                begin
                    src_next   = in_tok;
                    lctl.clear = 1'b1;
                    if (int'(in_tok) < int'(tcount_eff))
                    begin
                        cnt_next   = '0;
                        mac_clear  = 1'b1;
                        state_next = ST_SRC_MAC;
                    end
                    else
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_SRC_MAC:
            begin
                if (mac_done)
                begin
                    sq_start   = 1'b1;
                    state_next = ST_SRC_ROOT;
                end
            end
            ST_SRC_ROOT:
            begin
                if (sq_done)
                begin
                    ra_next    = sq_root;
                    j_next     = '0;
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT:
            begin
                if (j_reg >= tcount_eff)
                begin
                    state_next = ST_DRAIN;
                end
                else if (int'(j_reg) == int'(src_reg))
                begin
                    j_next = j_reg + 1'b1;
                end
                else
                begin
                    cnt_next   = '0;
                    mac_clear  = 1'b1;
                    state_next = ST_TGT_MAC;
                end
            end
            ST_TGT_MAC:
            begin
                if (mac_done)
                begin
                    sq_start   = 1'b1;
                    state_next = ST_TGT_ROOT;
                end
            end
            ST_TGT_ROOT:
            begin
                if (sq_done)
                begin
                    state_next = ST_DEN;
                end
            end
            ST_DEN:
            begin
                den_next   = DenW'(ra_reg) * DenW'(sq_root);
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (den_reg == '0)
                begin
                    sim_next   = '0;
                    state_next = ST_OFFER;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    sim_next   = sim_sat;
                    state_next = ST_OFFER;
                end
            end
            ST_OFFER:
            begin
                lctl.insert = (sim_reg > thr_reg);
                j_next      = j_reg + 1'b1;
                state_next  = ST_SELECT;
            end
            ST_DRAIN:
            begin
                if (out_load)
                begin
                    m_tvalid_next = 1'b1;
                    out_src_next  = src_reg;
                    if (lstat.head_valid)
                    begin
                        out_tgt_next   = TOK_W'(head_idx);
                        out_sim_next   = head_sim;
                        out_match_next = 1'b1;
                        out_last_next  = !lstat.more;
                        lctl.pop       = 1'b1;
                        if (!lstat.more)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        out_tgt_next   = '0;
                        out_sim_next   = '0;
                        out_match_next = 1'b0;
                        out_last_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rdv_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rdv_reg      <= rdv_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg       <= src_next;
        j_reg         <= j_next;
        cnt_reg       <= cnt_next;
        wc_reg        <= wc_next;
        ra_reg        <= ra_next;
        den_reg       <= den_next;
        sim_reg       <= sim_next;
        out_src_reg   <= out_src_next;
        out_tgt_reg   <= out_tgt_next;
        out_sim_reg   <= out_sim_next;
        out_match_reg <= out_match_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, out_sim_reg, out_tgt_reg, out_src_reg};
    assign m_tuser  = out_match_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

### rtl/core/ctnk_checker.sv
// Port-level checks of the neighbour search block, bound to the top level.
`default_nettype none
module ctnk_port_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [0:0]                       s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [ctnk_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [0:0]                       m_tuser,
    input logic                             m_tlast,
    input logic                             cfg_valid,
    input logic                             cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_nomatch_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata[35:10] == 26'd0))
        else $error("empty result malformed");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser[0] == ctnk_pkg::REQ_QUERY) |=> !s_tready)
        else $error("query did not hold off requests");

    a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser[0] == ctnk_pkg::REQ_LOAD) |=> s_tready)
        else $error("load blocked the next request");

    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind cosine_top_k_neighbors_top ctnk_port_checker u_ctnk_checker (.*);
`default_nettype wire

### sim/ctnk_checker.sv
// Checker for the neighbour search block: mirrors the store and registers, predicts and compares.
module ctnk_checker
    import ctnk_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [0:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic [0:0]            m_tuser,
    input  logic                  m_tlast,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [TOK_W-1:0]        src;
        logic [TOK_W-1:0]        tgt;
        logic signed [SIM_W-1:0] sim;
        logic                    has;
        logic                    last;
    } neighbour_t;

    logic signed [VAL_W-1:0] emb_mirror [0:DEF_MAX_TOKENS*DEF_MAX_DIM-1];
    neighbour_t              neighbours_due[$];

    logic signed [SIM_W-1:0] thr_q;
    logic [LIM_W-1:0]        lim_q;
    logic [TCNT_W-1:0]       tcnt_q;
    logic [VLEN_W-1:0]       vlen_q;

    initial
    begin
        for (int i = 0; i < DEF_MAX_TOKENS*DEF_MAX_DIM; i++)
            emb_mirror[i] = '0;
        errors = 0;
    end

    assign pending = neighbours_due.size();

    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= x)
                r = t;
        end
        return r;
    endfunction

    function automatic int cosine(input longint dot, input longint unsigned na,
                                  input longint unsigned nb);
        longint unsigned den;
        longint unsigned mag;
        longint unsigned q;
        if (na == 0 || nb == 0)
            return 0;
        den = floor_root(na << 4) * floor_root(nb << 4);
        if (den == 0)
            return 0;
        mag = (dot < 0) ? longint'(-dot) : longint'(dot);
        q = ((mag << FRAC_SHIFT) + (den >> 1)) / den;
        if (dot < 0)
            return (q >= 32768) ? -32768 : -int'(q);
        return (q >= 32767) ? 32767 : int'(q);
    endfunction

    function automatic void predict_neighbours(input logic [TOK_W-1:0] src);
        int          tc;
        int          vl;
        int          lim;
        int          cnt;
        int          pos;
        int          sim;
        int          best_sim [0:DEF_MAX_K-1];
        int          best_idx [0:DEF_MAX_K-1];
        longint      dot;
        longint unsigned na;
        longint unsigned nb;
        longint      a;
        longint      b;
        neighbour_t  r;
        tc  = (tcnt_q > DEF_MAX_TOKENS) ? DEF_MAX_TOKENS : int'(tcnt_q);
        vl  = (vlen_q > DEF_MAX_DIM) ? DEF_MAX_DIM : int'(vlen_q);
        lim = (lim_q > DEF_MAX_K) ? DEF_MAX_K : int'(lim_q);
        cnt = 0;
        if (int'(src) < tc)
        begin
            na = 0;
            for (int c = 0; c < vl; c++)
            begin
                a = emb_mirror[src*DEF_MAX_DIM + c];
                na += a * a;
            end
            for (int j = 0; j < tc; j++)
            begin
                if (j == int'(src))
                    continue;
                dot = 0;
                nb = 0;
                for (int c = 0; c < vl; c++)
                begin
                    a = emb_mirror[src*DEF_MAX_DIM + c];
                    b = emb_mirror[j*DEF_MAX_DIM + c];
                    dot += a * b;
                    nb += b * b;
                end
                sim = cosine(dot, na, nb);
                if (sim <= int'(thr_q) || lim == 0)
                    continue;
                pos = cnt;
                while (pos > 0 && (sim > best_sim[pos-1] ||
                       (sim == best_sim[pos-1] && j > best_idx[pos-1])))
                    pos--;
                if (pos >= lim)
                    continue;
                for (int k = (cnt < lim) ? cnt : lim - 1; k > pos; k--)
                begin
                    best_sim[k] = best_sim[k-1];
                    best_idx[k] = best_idx[k-1];
                end
                best_sim[pos] = sim;
                best_idx[pos] = j;
                if (cnt < lim)
                    cnt++;
            end
        end
        r.src = src;
        if (cnt == 0)
        begin
            r.tgt = '0;
            r.sim = '0;
            r.has = 1'b0;
            r.last = 1'b1;
            neighbours_due.insert(neighbours_due.size(), r);
        end
        for (int k = 0; k < cnt; k++)
        begin
            r.tgt = best_idx[k][TOK_W-1:0];
            r.sim = best_sim[k][SIM_W-1:0];
            r.has = 1'b1;
            r.last = (k == cnt - 1);
            neighbours_due.insert(neighbours_due.size(), r);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        neighbour_t e;
        logic [TOK_W-1:0]        got_src;
        logic [TOK_W-1:0]        got_tgt;
        logic signed [SIM_W-1:0] got_sim;
        if (!rst_n)
        begin
            thr_q  <= THR_RESET;
            lim_q  <= LIM_RESET;
            tcnt_q <= TCNT_RESET;
            vlen_q <= VLEN_RESET;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_src = m_tdata[9:0];
                got_tgt = m_tdata[19:10];
                got_sim = m_tdata[35:20];
                if (neighbours_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: src %0d tgt %0d sim %0d has %0b last %0b",
                                 got_src, got_tgt, got_sim, m_tuser[0], m_tlast);
                end
                else
                begin
                    e = neighbours_due.pop_front();
                    if (got_src !== e.src || got_tgt !== e.tgt || got_sim !== e.sim ||
                        m_tuser[0] !== e.has || m_tlast !== e.last)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp src %0d tgt %0d sim %0d has %0b last %0b, %s",
                                     e.src, e.tgt, e.sim, e.has, e.last,
                                     $sformatf("got src %0d tgt %0d sim %0d has %0b last %0b",
                                               got_src, got_tgt, got_sim, m_tuser[0],
                                               m_tlast));
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == REQ_LOAD)
                    emb_mirror[s_tdata[9:0]*DEF_MAX_DIM + s_tdata[17:10]] = s_tdata[33:18];
                else
                    predict_neighbours(s_tdata[9:0]);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_THRESHOLD: thr_q  <= cfg_data;
                    CFG_LIMIT:     lim_q  <= cfg_data[LIM_W-1:0];
                    CFG_TOKENS:    tcnt_q <= cfg_data[TCNT_W-1:0];
                    CFG_VLEN:      vlen_q <= cfg_data[VLEN_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

endmodule

### sim/tb.sv
// Testbench top: clock, reset, request stimulus, output back-pressure and the verdict.
module tb;
    import ctnk_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 500000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    logic                  quiet;
    int                    stall_left;
    int                    idle_cycles;

    cosine_top_k_neighbors_top u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    ctnk_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(negedge clk)
    begin
        logic rdy;
        rdy = 1'b1;
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rdy = 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 14);
            rdy = 1'b0;
        end
        m_tready <= rdy;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return VAL_W'($urandom_range(0, 64)) - 16'd32;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    task automatic send(input logic kind, input int tok, input int comp, input logic [15:0] val);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'b0, val, comp[COMP_W-1:0], tok[TOK_W-1:0]};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] thr, input int lim, input int tc, input int vl,
                             input int fill_from);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_LIMIT, 16'(lim));
        write_reg(CFG_TOKENS, 16'(tc));
        write_reg(CFG_VLEN, 16'(vl));
        for (int t = fill_from; t < tc; t++)
            for (int c = 0; c < vl; c++)
                send(REQ_LOAD, t, c, pick_value());
    endtask

    task automatic mixed_traffic(input int n, input int tc, input int vl);
        repeat (n)
        begin
            if ($urandom_range(0, 9) < 6)
                send(REQ_LOAD, $urandom_range(0, tc - 1), $urandom_range(0, vl - 1),
                     pick_value());
            else if ($urandom_range(0, 4) == 0)
                send(REQ_QUERY, $urandom_range(0, 1023), $urandom_range(0, 255), VAL_W'($urandom));
            else
                send(REQ_QUERY, $urandom_range(0, tc - 1), 0, 16'h0);
        end
    endtask

    initial
    begin
        logic [15:0] v;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        quiet      = 1'b0;
        stall_left = 0;
        idle_cycles = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        configure(16'h8000, 64, 8, 4, 8);
        for (int c = 0; c < 4; c++)
        begin
            v = 16'(c * 9000 - 13000);
            send(REQ_LOAD, 0, c, pick_value());
            send(REQ_LOAD, 1, c, v);
            send(REQ_LOAD, 2, c, v);
            send(REQ_LOAD, 3, c, v);
            send(REQ_LOAD, 4, c, -v);
            send(REQ_LOAD, 5, c, 16'h0);
            send(REQ_LOAD, 6, c, 16'h8000);
            send(REQ_LOAD, 7, c, 16'h8000);
        end
        send(REQ_QUERY, 1, 0, 16'h0);
        send(REQ_QUERY, 5, 0, 16'h0);
        send(REQ_QUERY, 6, 0, 16'h0);
        send(REQ_QUERY, 0, 0, 16'h0);
        send(REQ_QUERY, 100, 255, 16'hFFFF);
        send(REQ_QUERY, 1023, 0, 16'h0);
        mixed_traffic(10, 8, 4);
        drain();

        configure(16'd3277, 3, 12, 3, 8);
        mixed_traffic(10, 12, 3);
        drain();

        configure(16'h7FFF, 1, 1, 2, 1);
        send(REQ_QUERY, 0, 0, 16'h0);
        mixed_traffic(4, 1, 2);
        drain();

        configure(16'h8000, 0, 12, 0, 12);
        send(REQ_QUERY, 3, 0, 16'h0);
        send(REQ_QUERY, 11, 0, 16'h0);
        drain();

        configure(16'h8000, 2, 12, 0, 12);
        send(REQ_QUERY, 3, 0, 16'h0);
        drain();

        configure(16'h0000, 100, 12, 1, 12);
        mixed_traffic(6, 12, 1);
        drain();

        quiet = 1'b1;
        configure(16'hC000, 5, 12, 3, 12);
        mixed_traffic(15, 12, 3);
        drain();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### cosine_top_k_neighbors_top.f
rtl/core/ctnk_pkg.sv
rtl/core/ctnk_ram.sv
rtl/core/ctnk_mac.sv
rtl/core/ctnk_isqrt.sv
rtl/core/ctnk_div.sv
rtl/core/ctnk_list.sv
rtl/core/cosine_top_k_neighbors_top.sv
rtl/core/ctnk_checker.sv
sim/ctnk_checker.sv
sim/tb.sv
